>>> design/interval_table_first_fit_assert.svh
// Assertion macros for the interval table, empty when SYNTHESIS is defined.
`ifndef INTERVAL_TABLE_FIRST_FIT_ASSERT_SVH
`define INTERVAL_TABLE_FIRST_FIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ITFF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("interval table check failed");
`define ITFF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("interval table sequencing check failed");
`else
`define ITFF_ASSERT_IMP(lbl, ante, cons)
`define ITFF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> design/itff_pkg.sv
// Shared constants and types of the first-fit interval table.
package itff_pkg;

  localparam int SLOTS     = 32;
  localparam int TIME_BITS = 16;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int IN_W      = 56;
  localparam int OUT_W     = 48;

  localparam logic [5:0] MISS_LIMIT = 6'((SLOTS < 63) ? SLOTS : 63);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_PLACE  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [TIME_BITS-1:0] start_time;
    logic [TIME_BITS-1:0] stop_time;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> design/interval_table_first_fit.sv
// Interval table sorted by end time, with fixed insertion and first-fit placement.
//
// Items enter on s_tvalid/s_tready/s_tdata and one result item leaves per input
// item on m_tvalid/m_tready/m_tdata. The table lives in a RAM with a registered
// read port; one comparator with its adder is shared by the gap scan and the
// sorted-insert shift, which each step through one table entry per cycle.
// The block takes one item at a time: s_tready is high only while it is idle.
// Clear, unused opcodes, an insert into a full table and a placement that cannot scan
// go straight to the response state. A fixed insert passes through the start and shift
// states, moving up the entries that end after it. A placement that fits scans the gaps
// in order, then passes through the same start and shift states; one that finds no gap
// goes from the scan to the response state.
// Reset empties the table and clears the miss counter; table contents are not
// cleared, since only entries below the fill count are ever used.
// When the receiver stalls, the finished result waits in the output register; the
// block can take one more item meanwhile and holds its result until the register
// is free.
module interval_table_first_fit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // opcode[1:0], begin_time[17:2], end_time[33:18], length[49:34], zero pad
  input  logic [itff_pkg::IN_W-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // placed[0], placed_begin[16:1], placed_end[32:17], entry_count[38:33],
  // unplaced_count[44:39], zero pad
  output logic [itff_pkg::OUT_W-1:0] m_tdata
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_SHIFT = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  localparam int TB = itff_pkg::TIME_BITS;
  localparam int IW = itff_pkg::IDX_W;
  localparam int CW = itff_pkg::CNT_W;

  logic [2:0]    state;
  logic [IW-1:0] idx;
  logic [CW-1:0] held;
  logic [5:0]    miss;
  logic          placed;
  logic [TB-1:0] pb;
  logic [TB-1:0] pe;
  logic [TB-1:0] len;
  logic [TB-1:0] prev_end;

  logic [1:0]    in_opcode;
  logic [TB-1:0] in_begin;
  logic [TB-1:0] in_end;
  logic [TB-1:0] in_length;
  logic          accept;

  logic              we;
  logic [IW-1:0]     raddr;
  itff_pkg::entry_t  wentry;
  itff_pkg::entry_t  rentry;
  logic [itff_pkg::ENTRY_W-1:0] rword;

  logic [TB:0]   gap_sum;
  logic [TB-1:0] cmp_a;
  logic [TB:0]   cmp_b;
  logic          cmp_ge;
  logic          shift_stop;
  logic          last_gap;
  logic          out_free;

  assign in_opcode = s_tdata[1:0];
  assign in_begin  = s_tdata[17:2];
  assign in_end    = s_tdata[33:18];
  assign in_length = s_tdata[49:34];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign rentry = itff_pkg::entry_t'(rword);

  // Shared compare unit: the gap test is begin >= prev_end + len (one bit of
  // headroom keeps it exact); the insert test stops once an entry ends at or
  // before the new end.
  assign gap_sum = {1'b0, prev_end} + {1'b0, len};

  always_comb begin
    cmp_a = pe;
    cmp_b = {1'b0, rentry.stop_time};
    case (state)
      ST_SCAN: begin
        cmp_a = rentry.start_time;
        cmp_b = gap_sum;
      end
      default: begin
        cmp_a = pe;
        cmp_b = {1'b0, rentry.stop_time};
      end
    endcase
  end

  assign cmp_ge     = ({1'b0, cmp_a} >= cmp_b);
  assign shift_stop = (idx == '0) || cmp_ge;
  assign last_gap   = (CW'(idx) == held - CW'(1));

  always_comb begin
    raddr = '0;
    case (state)
      ST_SCAN:  raddr = idx + IW'(1);
      ST_START: raddr = IW'(held - CW'(1));
      ST_SHIFT: raddr = idx - IW'(2);
      default:  raddr = '0;
    endcase
  end

  assign we = (state == ST_SHIFT);

  always_comb begin
    if (shift_stop) begin
      wentry.start_time = pb;
      wentry.stop_time  = pe;
    end else begin
      wentry = rentry;
    end
  end

  itff_ram #(
    .WIDTH(itff_pkg::ENTRY_W),
    .DEPTH(itff_pkg::SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (idx),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rword)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      held     <= '0;
      miss     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            placed <= 1'b0;
            pb     <= '0;
            pe     <= '0;
            len    <= in_length;
            state  <= ST_RESP;
            case (in_opcode)
              itff_pkg::OP_INSERT: begin
                if (held < CW'(itff_pkg::SLOTS)) begin
                  pb    <= in_begin;
                  pe    <= in_end;
                  state <= ST_START;
                end
              end
              itff_pkg::OP_PLACE: begin
                if (held >= CW'(2) && held < CW'(itff_pkg::SLOTS)) begin
                  idx   <= '0;
                  state <= ST_SCAN;
                end else if (miss < itff_pkg::MISS_LIMIT) begin
                  miss <= miss + 6'd1;
                end
              end
              itff_pkg::OP_CLEAR: begin
                held <= '0;
              end
              default: begin
                held <= held;
              end
            endcase
          end
        end
        ST_SCAN: begin
          // The read data holds the entry at idx; prev_end is the end of idx - 1.
          if (idx == '0) begin
            prev_end <= rentry.stop_time;
            idx      <= idx + IW'(1);
          end else if (cmp_ge) begin
            pb    <= prev_end;
            pe    <= gap_sum[TB-1:0];
            state <= ST_START;
          end else if (last_gap) begin
            if (miss < itff_pkg::MISS_LIMIT) begin
              miss <= miss + 6'd1;
            end
            state <= ST_RESP;
          end else begin
            prev_end <= rentry.stop_time;
            idx      <= idx + IW'(1);
          end
        end
        ST_START: begin
          idx   <= IW'(held);
          state <= ST_SHIFT;
        end
        ST_SHIFT: begin
          // Entries ending after the new one move up by one, top first.
          if (shift_stop) begin
            held   <= held + CW'(1);
            placed <= 1'b1;
            state  <= ST_RESP;
          end else begin
            idx <= idx - IW'(1);
          end
        end
        ST_RESP: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (state != ST_RESP && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESP && out_free) begin
      m_tdata <= {3'b000, miss, 6'(held), pe, pb, placed};
    end
  end

  `include "interval_table_first_fit_assert.svh"

  `ITFF_ASSERT_IMP(a_held_bound, 1'b1, held <= CW'(itff_pkg::SLOTS))
  `ITFF_ASSERT_IMP(a_write_in_shift, we, state == ST_SHIFT && held < CW'(itff_pkg::SLOTS))
  `ITFF_ASSERT_IMP(a_placed_has_entry, m_tvalid && m_tdata[0], m_tdata[38:33] != 6'd0)
  `ITFF_ASSERT_NEXT(a_miss_steps, state != ST_IDLE && state != ST_SCAN, $stable(miss))

endmodule

>>> design/itff_ram.sv
// Generic single-write, single-read RAM with registered read data.
module itff_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> test/interval_table_first_fit_tb.sv
// Self-checking testbench for the first-fit interval table, with its own predictor.
module interval_table_first_fit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int TOTAL_ITEMS = 1900;
  localparam int DRAIN_CYCLES = 2 * itff_pkg::SLOTS + 16;
  localparam int DRAIN_LIMIT = 100000;

  // One result item, laid out so that a cast of m_tdata[44:0] lines up.
  typedef struct packed {
    logic [5:0]                     misses;
    logic [5:0]                     entries;
    logic [itff_pkg::TIME_BITS-1:0] stop;
    logic [itff_pkg::TIME_BITS-1:0] start;
    logic                           placed;
  } outcome_t;

  class interval_scoreboard;
    itff_pkg::entry_t slot_tab[itff_pkg::SLOTS];
    int unsigned held;
    logic [5:0]  misses;
    outcome_t    pending_q[$];
    int unsigned errors, checked, fits, misses_seen, rejects;

    function new();
      held = 0;
      misses = '0;
      errors = 0;
      checked = 0;
      fits = 0;
      misses_seen = 0;
      rejects = 0;
    endfunction

    // Sorted insert: the new entry lands after every entry whose end is not greater.
    function void add_entry(logic [itff_pkg::TIME_BITS-1:0] b,
                            logic [itff_pkg::TIME_BITS-1:0] e);
      int unsigned pos, k;
      pos = 0;
      while (pos < held && slot_tab[pos].stop_time <= e) pos++;
      for (k = held; k > pos; k--) slot_tab[k] = slot_tab[k-1];
      slot_tab[pos] = '{start_time: b, stop_time: e};
      held++;
    endfunction

    function void note_request(logic [1:0] op, logic [15:0] b, logic [15:0] e,
                               logic [15:0] len);
      outcome_t    res;
      int unsigned j;
      logic        found;
      res = '0;
      found = 1'b0;
      case (op)
        itff_pkg::OP_INSERT: begin
          if (held < itff_pkg::SLOTS) begin
            add_entry(b, e);
            res.placed = 1'b1;
            res.start = b;
            res.stop = e;
          end else begin
            rejects++;
          end
        end
        itff_pkg::OP_PLACE: begin
          if (held >= 2 && held < itff_pkg::SLOTS) begin
            for (j = 1; j < held && !found; j++) begin
              // A gap between overlapping neighbors never fits.
              if (slot_tab[j].start_time >= slot_tab[j-1].stop_time &&
                  slot_tab[j].start_time - slot_tab[j-1].stop_time >= len) begin
                found = 1'b1;
                res.start = slot_tab[j-1].stop_time;
                res.stop = slot_tab[j-1].stop_time + len;
              end
            end
          end
          if (found) begin
            add_entry(res.start, res.stop);
            res.placed = 1'b1;
            fits++;
          end else begin
            if (misses < itff_pkg::MISS_LIMIT) misses++;
            misses_seen++;
          end
        end
        itff_pkg::OP_CLEAR: held = 0;
        default: ;
      endcase
      res.entries = 6'(held);
      res.misses = misses;
      pending_q.push_back(res);
    endfunction

    function void flag(string what, outcome_t want, outcome_t got);
      errors++;
      if (errors <= 10) begin
        $write("%t %s: expected placed=%0d begin=%h end=%h count=%0d unplaced=%0d, ",
               $realtime, what, want.placed, want.start, want.stop, want.entries,
               want.misses);
        $display("got placed=%0d begin=%h end=%h count=%0d unplaced=%0d",
                 got.placed, got.start, got.stop, got.entries, got.misses);
      end
    endfunction

    function void check_result(logic [itff_pkg::OUT_W-1:0] data);
      outcome_t got, want;
      got = outcome_t'(data[44:0]);
      if (pending_q.size() == 0) begin
        flag("result with nothing outstanding", '0, got);
      end else begin
        want = pending_q.pop_front();
        checked++;
        if (got.placed !== want.placed) flag("placed differs", want, got);
        else if (got.start !== want.start) flag("placed_begin differs", want, got);
        else if (got.stop !== want.stop) flag("placed_end differs", want, got);
        else if (got.entries !== want.entries) flag("entry_count differs", want, got);
        else if (got.misses !== want.misses) flag("unplaced_count differs", want, got);
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [itff_pkg::IN_W-1:0]  s_tdata = '0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [itff_pkg::OUT_W-1:0] m_tdata;

  interval_scoreboard sb = new();
  int unsigned sent_items = 0;
  int          phase = 0;
  int unsigned src_idle = 0;
  int unsigned sink_stall = 0;

  interval_table_first_fit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      m_tready <= ($urandom_range(0, 99) >= sink_stall);
    end
  end

  // Lowers the request and waits until every outstanding result has come back or a guard limit is reached.
  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic send_item(logic [1:0] op, logic [15:0] b, logic [15:0] e,
                           logic [15:0] len);
    int ph;
    ph = sent_items * 4 / TOTAL_ITEMS;
    if (ph > 3) ph = 3;
    if (ph != phase) begin
      phase = ph;
      wait_drained();
      case (phase)
        1: begin src_idle = 49; sink_stall = 0; end
        2: begin src_idle = 0; sink_stall = 49; end
        default: begin src_idle = 25; sink_stall = 25; end
      endcase
    end
    while ($urandom_range(0, 99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, len, e, b, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(op, b, e, len);
    sent_items++;
  endtask

  function automatic logic [15:0] pick_length();
    case ($urandom_range(0, 9))
      0, 1: return 16'd0;
      2: return 16'($urandom);
      3, 4: return 16'($urandom_range(0, 16'h0800));
      default: return 16'($urandom_range(0, 16'h0100));
    endcase
  endfunction

  function automatic logic [1:0] random_op();
    if ($urandom_range(0, 19) == 0) return OP_UNUSED;
    return 2'($urandom_range(0, 2));
  endfunction

  task automatic run_directed();
    send_item(itff_pkg::OP_PLACE, 16'h0000, 16'h0000, 16'h0005);   // empty table
    send_item(itff_pkg::OP_INSERT, 16'h0000, 16'h0000, 16'hFFFF);
    send_item(itff_pkg::OP_PLACE, 16'hFFFF, 16'hFFFF, 16'h0000);   // one entry, no gap
    send_item(itff_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_item(itff_pkg::OP_PLACE, 16'h0000, 16'h0000, 16'h0000);   // zero length
    send_item(itff_pkg::OP_PLACE, 16'h0000, 16'h0000, 16'hFFFF);   // widest gap exactly
    send_item(itff_pkg::OP_CLEAR, 16'h1234, 16'h5678, 16'h9ABC);
    send_item(itff_pkg::OP_INSERT, 16'h0100, 16'h0200, 16'h0000);
    send_item(itff_pkg::OP_INSERT, 16'h0180, 16'h0400, 16'h0000);  // overlaps its neighbor
    send_item(itff_pkg::OP_INSERT, 16'h0900, 16'h0600, 16'h0000);  // end below begin
    send_item(itff_pkg::OP_INSERT, 16'h0800, 16'h0200, 16'h0000);  // equal end goes after
    send_item(itff_pkg::OP_INSERT, 16'h0C00, 16'h0D00, 16'h0000);
    send_item(itff_pkg::OP_PLACE, 16'h0000, 16'h0000, 16'h0010);
    send_item(itff_pkg::OP_PLACE, 16'h0000, 16'h0000, 16'h0300);
    send_item(itff_pkg::OP_PLACE, 16'h0000, 16'h0000, 16'h7000);   // nothing that wide
    send_item(OP_UNUSED, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_item(itff_pkg::OP_CLEAR, 16'h5555, 16'hAAAA, 16'h5555);
    send_item(itff_pkg::OP_PLACE, 16'h0000, 16'h0000, 16'h0000);
    send_item(itff_pkg::OP_INSERT, 16'h5555, 16'hAAAA, 16'h5555);
    send_item(itff_pkg::OP_INSERT, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_item(itff_pkg::OP_PLACE, 16'hFFFF, 16'hFFFF, 16'h0001);
  endtask

  // Mostly a clear, a batch of intervals and a few placements; otherwise noise.
  task automatic run_sequence();
    logic [15:0] starts[34];
    logic [15:0] stops[34];
    logic [15:0] tmp;
    int unsigned n, m, i, idx, cursor, b, dur;
    logic        descending;
    if ($urandom_range(0, 9) >= 7) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++)
        send_item(random_op(), 16'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      send_item(itff_pkg::OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 34) : $urandom_range(2, 14);
      cursor = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16'h8000)
                                           : $urandom_range(0, 16'h0400);
      for (i = 0; i < n; i++) begin
        dur = $urandom_range(0, 16'h0200);
        if ($urandom_range(0, 7) == 0 && cursor > 16'h0100)
          b = cursor - $urandom_range(1, 16'h0100);
        else
          b = cursor + $urandom_range(0, 16'h0180);
        starts[i] = 16'(b);
        stops[i] = 16'(b + dur);
        cursor = b + dur;
        if ($urandom_range(0, 15) == 0) begin
          tmp = starts[i];
          starts[i] = stops[i];
          stops[i] = tmp;
        end
      end
      // Descending order makes most inserts shift the whole table, since the ends mostly ascend.
      descending = ($urandom_range(0, 2) == 0);
      for (i = 0; i < n; i++) begin
        idx = descending ? n - 1 - i : i;
        send_item(itff_pkg::OP_INSERT, starts[idx], stops[idx], 16'($urandom));
      end
      m = $urandom_range(1, 8);
      for (i = 0; i < m; i++)
        send_item(itff_pkg::OP_PLACE, 16'($urandom), 16'($urandom), pick_length());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    wait_drained();
    while (sent_items < TOTAL_ITEMS) run_sequence();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $write("Covered %0d items: %0d first-fit placements, ", sent_items, sb.fits);
    $display("%0d lengths without a gap, %0d inserts refused by a full table.",
             sb.misses_seen, sb.rejects);
    $display("Checked %0d results, %0d errors, %0d still outstanding.",
             sb.checked, sb.errors, sb.pending_q.size());
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("interval_table_first_fit: match");
    else
      $display("interval_table_first_fit: mismatch");
    $finish;
  end

  initial begin
    #20ms;
    $display("interval_table_first_fit: mismatch");
    $finish;
  end

endmodule
